[rtl/core/rti_pkg.sv]
`default_nettype none
package rti_pkg;
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int DIST_WIDTH       = 31;
    localparam int QUOT_WIDTH       = DIST_WIDTH + 1;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int CFG_COUNT        = 6;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_Z    = 3'd5;

    localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};
endpackage
`default_nettype wire

[rtl/core/rti_mul.sv]
`default_nettype none
module rti_mul
    import rti_pkg::*;
#(
    parameter int AW = 33,
    parameter int BW = 32
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [AW-1:0]      a,
    input  logic signed [BW-1:0]      b,
    output logic signed [AW+BW-1:0]   p
);
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;

    logic signed [AW+BL:0]    lo_reg, lo_next;
    logic signed [AW+BH-1:0]  hi_reg, hi_next;
    logic signed [AW+BW-1:0]  p_reg, p_next;

    // two partial products on the halves of b, summed one stage later
    always_comb
    begin
        lo_next = a * $signed({1'b0, b[BL-1:0]});
        hi_next = a * $signed(b[BW-1:BL]);
        p_next  = $signed({hi_reg, {BL{1'b0}}}) + (AW+BW)'(lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;
endmodule
`default_nettype wire

[rtl/core/rti_div_stage.sv]
`default_nettype none
module rti_div_stage
    import rti_pkg::*;
#(
    parameter int EW = 104,
    parameter int QW = 152,
    parameter int SH = 31
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [QW-1:0]          rem_in,
    input  logic [EW-1:0]          den_in,
    input  logic [QUOT_WIDTH-1:0]  q_in,
    input  logic                   hit_in,
    output logic [QW-1:0]          rem_out,
    output logic [EW-1:0]          den_out,
    output logic [QUOT_WIDTH-1:0]  q_out,
    output logic                   hit_out
);
    logic [QW-1:0]         cand;
    logic [QW-1:0]         rem_reg, rem_next;
    logic [EW-1:0]         den_reg;
    logic [QUOT_WIDTH-1:0] q_reg, q_next;
    logic                  hit_reg;

    // one restoring step: take den shifted to this bit if it fits
    always_comb
    begin
        cand     = QW'(den_in) << SH;
        rem_next = rem_in;
        q_next   = q_in;
        if (rem_in >= cand)
        begin
            rem_next   = rem_in - cand;
            q_next[SH] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            q_reg   <= q_next;
            hit_reg <= hit_in;
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;
    assign hit_out = hit_reg;
endmodule
`default_nettype wire

[rtl/core/ray_triangle_intersect.sv]
// Ray / triangle intersection, one triangle per word against a fixed ray.
// Configuration: write registers 0..5 (origin x,y,z, direction x,y,z,
// signed Q.FRAC_BITS) on the cfg channel; cfg_ready is always high and
// writes to index 6 or 7 are dropped. Write only while the block is idle.
// Triangle channel: tri_valid with the nine vertex coordinates; a word is
// taken when tri_valid is high and tri_stall is low.
// Result channel: res_valid with hit and distance (t in Q.FRAC_BITS,
// truncated, saturated at all ones, 0 on a miss); taken when res_stall is low.
// Throughput: one triangle per cycle while tri_stall is low. A result passes
// through stages A to H, with the 32 stage restoring divider, to res_valid.
// A stalled result holds in the output register; the pipeline keeps
// advancing while its last stage is empty, then stalls the triangle side.
// Reset clears all valid bits and loads the ray origin 0 and direction
// (0, 0, 1.0).
`default_nettype none
module ray_triangle_intersect
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          tri_valid,
    output logic                          tri_stall,
    input  logic signed [COORD_WIDTH-1:0] v0_x,
    input  logic signed [COORD_WIDTH-1:0] v0_y,
    input  logic signed [COORD_WIDTH-1:0] v0_z,
    input  logic signed [COORD_WIDTH-1:0] v1_x,
    input  logic signed [COORD_WIDTH-1:0] v1_y,
    input  logic signed [COORD_WIDTH-1:0] v1_z,
    input  logic signed [COORD_WIDTH-1:0] v2_x,
    input  logic signed [COORD_WIDTH-1:0] v2_y,
    input  logic signed [COORD_WIDTH-1:0] v2_z,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          hit,
    output logic [DIST_WIDTH-1:0]         distance
);
    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int MW = 2 * CW + 2;
    localparam int NW = 2 * CW + 3;
    localparam int PW = 3 * CW + 6;
    localparam int EW = PW + 2;
    localparam int QW = EW + FRAC_BITS + QUOT_WIDTH;
    localparam int NS = 9 + QUOT_WIDTH;

    // configuration
    logic signed [CW-1:0] cfg_reg [CFG_COUNT];
    logic signed [CW-1:0] dir [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_ORIGIN_X] <= '0;
            cfg_reg[REG_ORIGIN_Y] <= '0;
            cfg_reg[REG_ORIGIN_Z] <= '0;
            cfg_reg[REG_DIR_X]    <= '0;
            cfg_reg[REG_DIR_Y]    <= '0;
            cfg_reg[REG_DIR_Z]    <= CW'(1) << FRAC_BITS;
        end
        else if (cfg_valid && cfg_ready && (cfg_index < CFG_INDEX_WIDTH'(CFG_COUNT)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign dir[0] = cfg_reg[REG_DIR_X];
    assign dir[1] = cfg_reg[REG_DIR_Y];
    assign dir[2] = cfg_reg[REG_DIR_Z];

    // flow control
    logic [NS-1:0] v_reg, v_next;
    logic          out_free, pipe_en;
    logic          res_valid_reg, res_valid_next;
    logic          hit_reg, hit_next;
    logic [DIST_WIDTH-1:0] dist_reg, dist_next;

    assign out_free  = !res_valid_reg || !res_stall;
    assign pipe_en   = out_free || !v_reg[NS-1];
    assign tri_stall = !pipe_en;
    assign v_next    = {v_reg[NS-2:0], tri_valid};

    // stage A: edge and origin differences
    logic signed [CW-1:0] p0 [3], p1 [3], p2 [3], org [3];
    logic signed [DW-1:0] u_reg [3], w_reg [3], s_reg [3];
    logic signed [DW-1:0] u_next [3], w_next [3], s_next [3];

    assign p0[0] = v0_x; assign p0[1] = v0_y; assign p0[2] = v0_z;
    assign p1[0] = v1_x; assign p1[1] = v1_y; assign p1[2] = v1_z;
    assign p2[0] = v2_x; assign p2[1] = v2_y; assign p2[2] = v2_z;
    assign org[0] = cfg_reg[REG_ORIGIN_X];
    assign org[1] = cfg_reg[REG_ORIGIN_Y];
    assign org[2] = cfg_reg[REG_ORIGIN_Z];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = DW'(p0[i]) - DW'(p1[i]);
            w_next[i] = DW'(p0[i]) - DW'(p2[i]);
            s_next[i] = DW'(p0[i]) - DW'(org[i]);
        end
    end

    // delay copies of u, w, s to line up with m and n
    logic signed [DW-1:0] ud_reg [3][3], wd_reg [3][3], sd_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= u_next[i];
                w_reg[i] <= w_next[i];
                s_reg[i] <= s_next[i];
                ud_reg[0][i] <= u_reg[i];
                wd_reg[0][i] <= w_reg[i];
                sd_reg[0][i] <= s_reg[i];
                for (int k = 1; k < 3; k++)
                begin
                    ud_reg[k][i] <= ud_reg[k-1][i];
                    wd_reg[k][i] <= wd_reg[k-1][i];
                    sd_reg[k][i] <= sd_reg[k-1][i];
                end
            end
        end
    end

    // stage B: cross products w x dir and u x s
    logic signed [DW+CW-1:0] pma [3], pmb [3];
    logic signed [2*DW-1:0]  pna [3], pnb [3];
    logic signed [DW-1:0]    na_a [3], na_b [3], nb_a [3], nb_b [3];

    assign na_a[0] = u_reg[0]; assign na_b[0] = s_reg[1];
    assign nb_a[0] = s_reg[0]; assign nb_b[0] = u_reg[1];
    assign na_a[1] = s_reg[0]; assign na_b[1] = u_reg[2];
    assign nb_a[1] = u_reg[0]; assign nb_b[1] = s_reg[2];
    assign na_a[2] = u_reg[1]; assign na_b[2] = s_reg[2];
    assign nb_a[2] = s_reg[1]; assign nb_b[2] = u_reg[2];

    for (genvar i = 0; i < 3; i++)
    begin : g_cross
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        rti_mul #(.AW(DW), .BW(CW)) u_ma (.clk(clk), .en(pipe_en),
            .a(w_reg[J]), .b(dir[K]), .p(pma[i]));
        rti_mul #(.AW(DW), .BW(CW)) u_mb (.clk(clk), .en(pipe_en),
            .a(w_reg[K]), .b(dir[J]), .p(pmb[i]));
        rti_mul #(.AW(DW), .BW(DW)) u_na (.clk(clk), .en(pipe_en),
            .a(na_a[i]), .b(na_b[i]), .p(pna[i]));
        rti_mul #(.AW(DW), .BW(DW)) u_nb (.clk(clk), .en(pipe_en),
            .a(nb_a[i]), .b(nb_b[i]), .p(pnb[i]));
    end

    // stage C: m and n
    logic signed [MW-1:0] m_reg [3];
    logic signed [NW-1:0] n_reg [3];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= MW'(pma[i]) - MW'(pmb[i]);
                n_reg[i] <= NW'(pna[i]) - NW'(pnb[i]);
            end
        end
    end

    // stage D: dot product terms
    logic signed [DW+MW-1:0] tden [3], tnb [3];
    logic signed [CW+NW-1:0] tng [3];
    logic signed [DW+NW-1:0] tnt [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        rti_mul #(.AW(DW), .BW(MW)) u_den (.clk(clk), .en(pipe_en),
            .a(ud_reg[2][i]), .b(m_reg[i]), .p(tden[i]));
        rti_mul #(.AW(DW), .BW(MW)) u_nbt (.clk(clk), .en(pipe_en),
            .a(sd_reg[2][i]), .b(m_reg[i]), .p(tnb[i]));
        rti_mul #(.AW(CW), .BW(NW)) u_ngt (.clk(clk), .en(pipe_en),
            .a(dir[2-i]), .b(n_reg[i]), .p(tng[i]));
        rti_mul #(.AW(DW), .BW(NW)) u_ntt (.clk(clk), .en(pipe_en),
            .a(wd_reg[2][2-i]), .b(n_reg[i]), .p(tnt[i]));
    end

    // stage E: sums
    logic signed [PW-1:0] den_reg, nb_reg, ng_reg, nt_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            den_reg <= PW'(tden[0]) + PW'(tden[1]) + PW'(tden[2]);
            nb_reg  <= PW'(tnb[0]) + PW'(tnb[1]) + PW'(tnb[2]);
            ng_reg  <= PW'(tng[0]) + PW'(tng[1]) + PW'(tng[2]);
            nt_reg  <= -(PW'(tnt[0]) + PW'(tnt[1]) + PW'(tnt[2]));
        end
    end

    // stage F: make the determinant nonnegative
    logic signed [EW-1:0] fden_reg, fnb_reg, fng_reg, fnt_reg;
    logic                 neg;

    assign neg = den_reg[PW-1];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            fden_reg <= neg ? -EW'(den_reg) : EW'(den_reg);
            fnb_reg  <= neg ? -EW'(nb_reg)  : EW'(nb_reg);
            fng_reg  <= neg ? -EW'(ng_reg)  : EW'(ng_reg);
            fnt_reg  <= neg ? -EW'(nt_reg)  : EW'(nt_reg);
        end
    end

    // stage G: inside tests; a zero determinant fails the beta range
    logic signed [EW-1:0] d_nb, d_nbg;
    logic                 in_hit;
    logic [QW-1:0]        g_rem_reg;
    logic [EW-1:0]        g_den_reg;
    logic                 g_hit_reg;

    always_comb
    begin
        d_nb   = fden_reg - fnb_reg;
        d_nbg  = fden_reg - fnb_reg - fng_reg;
        in_hit = (fnb_reg > 0) && (d_nb > 0) && (fng_reg > 0)
                 && (d_nbg > 0) && (fnt_reg > 0);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            g_rem_reg <= QW'($unsigned(fnt_reg)) << FRAC_BITS;
            g_den_reg <= $unsigned(fden_reg);
            g_hit_reg <= in_hit;
        end
    end

    // stage H: divider, top quotient bit flags saturation
    logic [QW-1:0]         rem_c [QUOT_WIDTH+1];
    logic [EW-1:0]         den_c [QUOT_WIDTH+1];
    logic [QUOT_WIDTH-1:0] q_c   [QUOT_WIDTH+1];
    logic                  hit_c [QUOT_WIDTH+1];

    assign rem_c[0] = g_rem_reg;
    assign den_c[0] = g_den_reg;
    assign q_c[0]   = '0;
    assign hit_c[0] = g_hit_reg;

    for (genvar k = 0; k < QUOT_WIDTH; k++)
    begin : g_div
        rti_div_stage #(.EW(EW), .QW(QW), .SH(QUOT_WIDTH - 1 - k)) u_stage (
            .clk(clk), .en(pipe_en),
            .rem_in(rem_c[k]), .den_in(den_c[k]), .q_in(q_c[k]), .hit_in(hit_c[k]),
            .rem_out(rem_c[k+1]), .den_out(den_c[k+1]), .q_out(q_c[k+1]),
            .hit_out(hit_c[k+1]));
    end

    // output register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        hit_next       = hit_reg;
        dist_next      = dist_reg;
        if (out_free)
        begin
            res_valid_next = v_reg[NS-1];
            hit_next       = hit_c[QUOT_WIDTH];
            if (!hit_c[QUOT_WIDTH])
                dist_next = '0;
            else if (q_c[QUOT_WIDTH][QUOT_WIDTH-1])
                dist_next = DIST_MAX;
            else
                dist_next = q_c[QUOT_WIDTH][DIST_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pipe_en)
                v_reg <= v_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        dist_reg <= dist_next;
    end

    assign res_valid = res_valid_reg;
    assign hit       = hit_reg;
    assign distance  = dist_reg;
endmodule
`default_nettype wire
